// ===== design/mmss_pkg.sv =====
// Shared constants for the minutes:seconds countdown timer.
package mmss_pkg;

    localparam int SEC_W = 6;
    localparam int MIN_W = 2;
    localparam int DISP_W = 8;
    localparam int LED_W = 3;

    localparam logic [SEC_W-1:0] SEC_MAX = 6'd59;

    localparam logic [DISP_W-1:0] BLINK_ON = 8'hFF;
    localparam logic [DISP_W-1:0] BLINK_OFF = 8'h00;

    localparam logic [LED_W-1:0] LED_RED = 3'h1;
    localparam logic [LED_W-1:0] LED_GREEN = 3'h2;
    localparam logic [LED_W-1:0] LED_BLUE = 3'h4;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

// ===== design/mmss_countdown_timer.sv =====
// Minutes:seconds countdown timer with button polls, one-second ticks and expiry blink.
// Each result is registered and valid in the cycle after its input is accepted.
// Throughput: one per cycle while results are taken; one state/result register sets it.
// Input ready stays high while the result register is empty or being taken.
// Reset (synchronous, active low): time 0:00, set mode on, not running, not blinking,
// display and leds cleared, no result pending.
module mmss_countdown_timer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic       i_start_pressed,
    input  logic       i_stop_pressed,
    input  logic       i_set_pressed,
    input  logic       i_reset_pressed,
    input  logic       i_up_pressed,
    input  logic       i_down_pressed,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_display,
    output logic [2:0] o_leds,
    output logic       o_in_set_mode,
    output logic       o_is_running,
    output logic       o_is_blinking
);

    logic [mmss_pkg::SEC_W-1:0]  r_sec,  n_sec;
    logic [mmss_pkg::MIN_W-1:0]  r_min,  n_min;
    logic                        r_set_mode, n_set_mode;
    logic                        r_running,  n_running;
    logic                        r_blinking, n_blinking;
    logic                        r_phase,    n_phase;
    logic [mmss_pkg::DISP_W-1:0] r_display,  n_display;
    logic [mmss_pkg::LED_W-1:0]  r_leds,     n_leds;
    logic                        r_out_valid;
    logic                        w_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_sec      = r_sec;
        n_min      = r_min;
        n_set_mode = r_set_mode;
        n_running  = r_running;
        n_blinking = r_blinking;
        n_phase    = r_phase;
        n_display  = r_display;
        n_leds     = r_leds;
        if (i_op == mmss_pkg::OP_POLL) begin
            if (i_start_pressed) begin
                if (r_sec != '0 || r_min != '0) begin
                    n_set_mode = 1'b0;
                    n_running  = 1'b1;
                    n_leds     = mmss_pkg::LED_GREEN;
                end
            end else if (i_stop_pressed) begin
                n_running = 1'b0;
                n_leds    = mmss_pkg::LED_RED;
            end else if (i_set_pressed) begin
                n_running  = 1'b0;
                n_set_mode = 1'b1;
                n_blinking = 1'b0;
                n_leds     = mmss_pkg::LED_GREEN;
            end else if (i_reset_pressed) begin
                n_running  = 1'b0;
                n_set_mode = 1'b1;
                n_blinking = 1'b0;
                n_leds     = mmss_pkg::LED_RED;
                n_sec      = '0;
                n_min      = '0;
            end
            if (n_set_mode) begin
                if (i_up_pressed && !i_down_pressed) begin
                    if (n_sec >= mmss_pkg::SEC_MAX) begin
                        n_sec = '0;
                        n_min = n_min + 1'b1;
                    end else begin
                        n_sec = n_sec + 1'b1;
                    end
                end else if (i_down_pressed && !i_up_pressed) begin
                    if (n_sec == '0) begin
                        n_sec = mmss_pkg::SEC_MAX;
                        n_min = n_min - 1'b1;
                    end else begin
                        n_sec = n_sec - 1'b1;
                    end
                end
            end
            if (!n_blinking) begin
                n_display = {n_min, n_sec};
            end
        end else begin
            if (r_set_mode) begin
                n_leds = r_leds | mmss_pkg::LED_GREEN;
            end
            if (r_running) begin
                n_leds = mmss_pkg::LED_BLUE;
                if (r_sec != '0) begin
                    n_sec = r_sec - 1'b1;
                end else if (r_min != '0) begin
                    n_sec = mmss_pkg::SEC_MAX;
                    n_min = r_min - 1'b1;
                end else begin
                    n_blinking = 1'b1;
                    n_phase    = 1'b0;
                    n_running  = 1'b0;
                end
                n_display = {n_min, n_sec};
            end
            if (n_blinking) begin
                n_display = n_phase ? mmss_pkg::BLINK_OFF : mmss_pkg::BLINK_ON;
                n_phase   = !n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= '0;
            r_min       <= '0;
            r_set_mode  <= 1'b1;
            r_running   <= 1'b0;
            r_blinking  <= 1'b0;
            r_phase     <= 1'b0;
            r_display   <= '0;
            r_leds      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_sec      <= n_sec;
                r_min      <= n_min;
                r_set_mode <= n_set_mode;
                r_running  <= n_running;
                r_blinking <= n_blinking;
                r_phase    <= n_phase;
                r_display  <= n_display;
                r_leds     <= n_leds;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_display     = r_display;
    assign o_leds        = r_leds;
    assign o_in_set_mode = r_set_mode;
    assign o_is_running  = r_running;
    assign o_is_blinking = r_blinking;

endmodule

// ===== design/mmss_countdown_timer_checker.sv =====
// Port-level checks for the countdown timer, bound to its top level.
module mmss_countdown_timer_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_display,
    input logic       o_in_set_mode,
    input logic       o_is_running,
    input logic       o_is_blinking
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_display))
        else $error("result changed while stalled");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_run_vs_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_running && o_in_set_mode))
        else $error("running while in set mode");

    a_run_vs_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_running && o_is_blinking))
        else $error("running while blinking");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_blinking |-> o_display[5:0] <= mmss_pkg::SEC_MAX)
        else $error("seconds out of range");

endmodule

bind mmss_countdown_timer mmss_countdown_timer_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_display     (o_display),
    .o_in_set_mode (o_in_set_mode),
    .o_is_running  (o_is_running),
    .o_is_blinking (o_is_blinking)
);
